>>> hdl/des_pkg.sv
// Package: DES constants, permutation tables, S-boxes and round helper functions.
`default_nettype none

package des_pkg;

  localparam int BLOCK_W = 64;
  localparam int KEY_W   = 64;
  localparam int HALF_W  = 32;
  localparam int CD_W    = 56;
  localparam int SUBK_W  = 48;
  localparam int ROUNDS  = 16;
  localparam int ROUND_W = $clog2(ROUNDS);

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [HALF_W-1:0]  half_t;
  typedef logic [CD_W-1:0]    cd_t;
  typedef logic [SUBK_W-1:0]  subkey_t;
  typedef logic [ROUND_W-1:0] round_idx_t;

  // Table entries number bits 1..N from the most significant end.
  localparam logic [6:0] IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [5:0] E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // Total left rotation of the C and D halves once round n is reached.
  localparam logic [4:0] ROT_SUM [ROUNDS] = '{
    5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
    5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
  };

  localparam logic [3:0] SBOX [8][4][16] = '{
    '{'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7},
      '{4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8},
      '{4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0},
      '{4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13}},
    '{'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10},
      '{4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5},
      '{4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15},
      '{4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9}},
    '{'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8},
      '{4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1},
      '{4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7},
      '{4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12}},
    '{'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15},
      '{4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9},
      '{4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4},
      '{4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14}},
    '{'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9},
      '{4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6},
      '{4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14},
      '{4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3}},
    '{'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11},
      '{4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8},
      '{4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6},
      '{4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13}},
    '{'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1},
      '{4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6},
      '{4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2},
      '{4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12}},
    '{'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7},
      '{4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2},
      '{4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8},
      '{4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}}
  };

  function automatic block_t des_init_perm(input block_t src);
    block_t res;
    for (int i = 0; i < 64; i++) res[63-i] = src[6'(64 - int'(IP_TAB[i]))];
    return res;
  endfunction

  function automatic block_t des_final_perm(input block_t src);
    block_t res;
    for (int i = 0; i < 64; i++) res[63-i] = src[6'(64 - int'(FP_TAB[i]))];
    return res;
  endfunction

  function automatic cd_t des_pc1(input key_t key);
    cd_t res;
    for (int i = 0; i < 56; i++) res[55-i] = key[6'(64 - int'(PC1_TAB[i]))];
    return res;
  endfunction

  function automatic logic [27:0] des_rot28(input logic [27:0] half, input logic [4:0] amt);
    logic [55:0] dbl;
    dbl = {half, half} << amt;
    return dbl[55:28];
  endfunction

  // Subkey of one round; rnd is a constant at each use, so this folds to wiring.
  function automatic subkey_t des_subkey(input cd_t cd, input round_idx_t rnd);
    cd_t     rot;
    subkey_t res;
    rot = {des_rot28(cd[55:28], ROT_SUM[rnd]), des_rot28(cd[27:0], ROT_SUM[rnd])};
    for (int i = 0; i < 48; i++) res[47-i] = rot[6'(56 - int'(PC2_TAB[i]))];
    return res;
  endfunction

  function automatic half_t des_feistel(input half_t half, input subkey_t subkey);
    subkey_t    mixed;
    half_t      sout;
    half_t      res;
    logic [5:0] chunk;
    for (int i = 0; i < 48; i++) mixed[47-i] = half[5'(32 - int'(E_TAB[i]))];
    mixed = mixed ^ subkey;
    for (int b = 0; b < 8; b++) begin
      chunk = mixed[47-6*b -: 6];
      sout[31-4*b -: 4] = SBOX[b][{chunk[5], chunk[0]}][chunk[4:1]];
    end
    for (int i = 0; i < 32; i++) res[31-i] = sout[5'(32 - int'(P_TAB[i]))];
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/des_if.sv
// Interfaces: plaintext and ciphertext stream channels with valid/ready.
`default_nettype none

interface des_plain_if
  import des_pkg::*;
();
  logic   valid;
  logic   ready;
  block_t plain_block;
  modport source(output valid, output plain_block, input ready);
  modport sink(input valid, input plain_block, output ready);
endinterface

interface des_cipher_if
  import des_pkg::*;
();
  logic   valid;
  logic   ready;
  block_t cipher_block;
  modport source(output valid, output cipher_block, input ready);
  modport sink(input valid, input cipher_block, output ready);
endinterface

`default_nettype wire

>>> hdl/des_block_encrypt_unit.sv
// Top level: sixteen-stage pipelined DES encryption engine with key register.
`default_nettype none

// DES encryption, one 64-bit block per clock unless out_ch stalls. A plaintext
// beat accepted on in_ch passes the initial permutation and enters the first of
// sixteen round stages; each stage holds one Feistel round (expansion, subkey XOR,
// eight S-boxes, P permutation) and its own valid bit. The sixteenth stage register
// is the output register: its ciphertext, after the swap and inverse permutation
// (pure wiring), is shown on out_ch. Sustained throughput is one beat per cycle
// while out_ch does not stall, set by the one-round-per-stage pipeline. Each
// stage advances when it is empty or when the stage after it advances, so bubbles
// collapse and a stalled out_ch holds every item in place without loss or repeat.
// The key is written through cfg_we/cfg_wdata (bit 63 is DES key bit 1, parity
// bits are ignored); all sixteen subkeys are fixed wiring from the key register,
// so a key write must happen only while the pipeline is empty. Reset clears the
// key to zero and empties the pipeline; there is no start-up sweep.
module des_block_encrypt_unit
  import des_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_we,
  input  wire key_t     cfg_wdata,
  des_plain_if.sink     in_ch,
  des_cipher_if.source  out_ch
);

  key_t    key_r;
  cd_t     key_cd;
  subkey_t subkey [ROUNDS];

  logic  [ROUNDS:0] go;
  logic             stg_vld [ROUNDS];
  half_t            stg_l   [ROUNDS];
  half_t            stg_r   [ROUNDS];
  block_t           ip_blk;

  // Key register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      key_r <= cfg_wdata;
    end
  end

  assign key_cd = des_pc1(key_r);

  // Advance chain: a stage may load when empty or when its successor moves on.
  assign go[ROUNDS] = out_ch.ready;
  assign ip_blk     = des_init_perm(in_ch.plain_block);
  assign in_ch.ready = go[0];

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    assign subkey[g] = des_subkey(key_cd, ROUND_W'(g));
    assign go[g]     = !stg_vld[g] || go[g+1];

    if (g == 0) begin : g_first
      des_round u_round (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (go[g]),
        .in_vld (in_ch.valid),
        .in_l   (ip_blk[63:32]),
        .in_r   (ip_blk[31:0]),
        .subkey (subkey[g]),
        .vld_r  (stg_vld[g]),
        .l_r    (stg_l[g]),
        .r_r    (stg_r[g])
      );
    end else begin : g_next
      des_round u_round (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (go[g]),
        .in_vld (stg_vld[g-1]),
        .in_l   (stg_l[g-1]),
        .in_r   (stg_r[g-1]),
        .subkey (subkey[g]),
        .vld_r  (stg_vld[g]),
        .l_r    (stg_l[g]),
        .r_r    (stg_r[g])
      );
    end
  end

  // Last stage is the output register; swap halves and undo the initial permutation.
  assign out_ch.valid        = stg_vld[ROUNDS-1];
  assign out_ch.cipher_block = des_final_perm({stg_r[ROUNDS-1], stg_l[ROUNDS-1]});

endmodule

`default_nettype wire

>>> hdl/des_round.sv
// One pipeline stage: a DES Feistel round with its valid bit and half-block registers.
`default_nettype none

module des_round
  import des_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    adv,
  input  wire logic    in_vld,
  input  wire half_t   in_l,
  input  wire half_t   in_r,
  input  wire subkey_t subkey,
  output logic         vld_r,
  output half_t        l_r,
  output half_t        r_r
);

  half_t l_nxt;
  half_t r_nxt;

  always_comb begin
    l_nxt = in_r;
    r_nxt = in_l ^ des_feistel(in_r, subkey);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  // Payload needs no reset; load only on a real beat.
  always_ff @(posedge clk) begin
    if (adv && in_vld) begin
      l_r <= l_nxt;
      r_r <= r_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/des_chk.sv
// Checker: port-level assertions for the DES encryption engine, bound to the top level.
`default_nettype none

module des_chk
  import des_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst_n,
  input wire logic   in_ready,
  input wire logic   out_valid,
  input wire logic   out_ready,
  input wire block_t out_data
);

  // Synchronous reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // An empty output stage means nothing downstream blocks, so input must be open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage is empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output payload changed while stalled");

endmodule

bind des_block_encrypt_unit des_chk u_des_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.cipher_block)
);

`default_nettype wire
